// ----- rtl/buddy_pkg.sv -----
// ----------------------------------------------------------------------------
// buddy_pkg: shared types and constants for the buddy allocator
// Payload structs, node codes, status codes, default sizes and the command and status types.
// ----------------------------------------------------------------------------
`default_nettype none
package buddy_pkg;
  localparam int unsigned PoolLog2Def = 16;
  localparam int unsigned MinLog2Def  = 6;
  localparam logic [9:0]  HeaderReset = 10'd128;

  localparam logic [1:0] NsUnused = 2'd0;
  localparam logic [1:0] NsFree   = 2'd1;
  localparam logic [1:0] NsSplit  = 2'd2;
  localparam logic [1:0] NsAlloc  = 2'd3;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StBadSize = 2'd1;
  localparam logic [1:0] StNoRoom  = 2'd2;
  localparam logic [1:0] StBadFree = 2'd3;

  localparam logic KindAlloc = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_size;
    logic [15:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data_address;
    logic [4:0]  block_size_log2;
  } rsp_t;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdClrStep, CmdRead, CmdScanNext, CmdSplit,
    CmdMarkAlloc, CmdDescend, CmdMarkFree, CmdMerge, CmdFinish
  } cmd_e;

  typedef struct packed {
    logic       clr_done;
    logic       is_alloc;
    logic       bad_size;
    logic       too_big;
    logic       bad_addr;
    logic [1:0] rd;
    logic       scan_last;
    logic       scan_top;
    logic       at_target;
    logic       addr_match;
    logic       at_leaf;
    logic       at_root;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/buddy_dp.sv -----
// ----------------------------------------------------------------------------
// buddy_dp: buddy allocator datapath
// Node status memory, index/depth registers, size rounding and result.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_dp #(
  parameter int unsigned POOL_LOG2 = buddy_pkg::PoolLog2Def,
  parameter int unsigned MIN_LOG2  = buddy_pkg::MinLog2Def
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [9:0]      cfg_wdata_i,
  input  wire buddy_pkg::req_t req_i,
  input  wire buddy_pkg::cmd_e cmd_i,
  output buddy_pkg::stat_t     stat_o,
  output buddy_pkg::rsp_t      rsp_o
);
  localparam int unsigned Levels = POOL_LOG2 - MIN_LOG2;
  localparam int unsigned IdxW   = Levels + 1;
  localparam int unsigned DepW   = $clog2(Levels + 2);
  localparam int unsigned NeedW  = (POOL_LOG2 > 16 ? POOL_LOG2 : 16) + 2;
  localparam int unsigned AddrW  = POOL_LOG2 + 1;

  logic [1:0]      mem_q [2**IdxW];
  logic [IdxW-1:0] idx_q, idx_d;
  logic [DepW-1:0] dep_q, dep_d, tgt_q, tgt_d;
  logic [IdxW-1:0] clr_q;
  logic            clr_done_q;
  logic [9:0]      hdr_q;
  logic [1:0]      rd_q;
  logic [4:0]      k_q, k_d;
  logic [AddrW-1:0] a_q, a_d;
  buddy_pkg::req_t req_q;
  buddy_pkg::rsp_t rsp_q, rsp_d;
  logic [NeedW-1:0] need;
  logic            too_big;
  logic            we;
  logic [IdxW-1:0] wa;
  logic [1:0]      wd;
  logic            we2;
  logic [IdxW-1:0] wa2;
  logic [1:0]      wd2;
  logic [IdxW-1:0] ra;
  logic [AddrW-1:0] node_addr;
  logic [IdxW-1:0] lvl_base;

  assign need = NeedW'(req_q.request_size) + NeedW'(hdr_q);

  // smallest k >= MIN_LOG2 with 2^k >= need
  always_comb begin
    k_d = 5'(MIN_LOG2);
    too_big = 1'b1;
    for (int k = POOL_LOG2; k >= int'(MIN_LOG2); k--) begin
      if ((NeedW'(1) << k) >= need) begin
        k_d = 5'(k);
        too_big = 1'b0;
      end
    end
  end

  assign lvl_base  = IdxW'(1) << dep_q;
  assign node_addr = AddrW'(idx_q - lvl_base) << (POOL_LOG2 - dep_q);

  always_comb begin
    idx_d = idx_q;
    dep_d = dep_q;
    tgt_d = tgt_q;
    a_d   = a_q;
    rsp_d = rsp_q;
    we = 1'b0; wa = idx_q; wd = buddy_pkg::NsFree;
    we2 = 1'b0; wa2 = idx_q ^ IdxW'(1); wd2 = buddy_pkg::NsFree;
    ra = idx_q;
    case (cmd_i)
      buddy_pkg::CmdLoad: begin
        idx_d = IdxW'(1);
        dep_d = '0;
        tgt_d = DepW'(POOL_LOG2 - k_d);
        a_d   = AddrW'(req_q.free_address) - AddrW'(hdr_q);
        rsp_d = '0;
        if (req_q.kind == buddy_pkg::KindAlloc) begin
          // start the scan at the target level
          dep_d = DepW'(POOL_LOG2 - k_d);
          idx_d = IdxW'(1) << dep_d;
        end else begin
          rsp_d.data_address = req_q.free_address;
        end
        ra = idx_d;
      end
      buddy_pkg::CmdClrStep: begin
        we = 1'b1; wa = clr_q;
        wd = (clr_q == IdxW'(1)) ? buddy_pkg::NsFree : buddy_pkg::NsUnused;
      end
      buddy_pkg::CmdScanNext: begin
        if (idx_q == ((lvl_base << 1) - IdxW'(1))) begin
          dep_d = dep_q - DepW'(1);
          idx_d = IdxW'(1) << dep_d;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
        ra = idx_d;
      end
      buddy_pkg::CmdSplit: begin
        we = 1'b1; wd = buddy_pkg::NsSplit;
        we2 = 1'b1; wa2 = {idx_q[IdxW-2:0], 1'b1}; wd2 = buddy_pkg::NsFree;
        idx_d = {idx_q[IdxW-2:0], 1'b0};
        dep_d = dep_q + DepW'(1);
      end
      buddy_pkg::CmdMarkAlloc: begin
        we = 1'b1; wd = buddy_pkg::NsAlloc;
        rsp_d.status = buddy_pkg::StDone;
        rsp_d.data_address = 16'(NeedW'(node_addr) + NeedW'(hdr_q));
        rsp_d.block_size_log2 = k_q;
      end
      buddy_pkg::CmdDescend: begin
        idx_d = {idx_q[IdxW-2:0], a_q[POOL_LOG2 - 32'(dep_q) - 1]};
        dep_d = dep_q + DepW'(1);
        ra = idx_d;
      end
      buddy_pkg::CmdMarkFree: begin
        we = 1'b1; wd = buddy_pkg::NsFree;
        rsp_d.block_size_log2 = 5'(POOL_LOG2 - dep_q);
        ra = idx_q ^ IdxW'(1);
      end
      buddy_pkg::CmdMerge: begin
        we = 1'b1; wd = buddy_pkg::NsUnused;
        we2 = 1'b1; wd2 = buddy_pkg::NsUnused;
        idx_d = idx_q >> 1;
        dep_d = dep_q - DepW'(1);
        rsp_d.block_size_log2 = 5'(POOL_LOG2 - dep_d);
        ra = idx_d ^ IdxW'(1);
      end
      buddy_pkg::CmdFinish: begin
        // the current node (parent of the last merge, if any) becomes free
        we = 1'b1; wd = buddy_pkg::NsFree;
      end
      buddy_pkg::CmdRead: ra = idx_q;
      default: ;
    endcase
  end

  // error results are set by the controller through the status code
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (we2) mem_q[wa2] <= wd2;
  end

  // read port: registered, with write-through of this cycle's writes;
  // wait cycles keep the last read
  always_ff @(posedge clk_i) begin
    if (cmd_i != buddy_pkg::CmdNone) begin
      if (we && wa == ra) rd_q <= wd;
      else if (we2 && wa2 == ra) rd_q <= wd2;
      else rd_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      clr_done_q <= 1'b0;
      hdr_q <= buddy_pkg::HeaderReset;
    end else begin
      if (cfg_we_i) hdr_q <= cfg_wdata_i;
      if (cmd_i == buddy_pkg::CmdClrStep) begin
        clr_q <= clr_q + IdxW'(1);
        if (clr_q == '1) clr_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == buddy_pkg::CmdNone) req_q <= req_i;
    idx_q <= idx_d;
    dep_q <= dep_d;
    tgt_q <= tgt_d;
    a_q   <= a_d;
    rsp_q <= rsp_d;
    if (cmd_i == buddy_pkg::CmdLoad) k_q <= k_d;
  end

  always_comb begin
    stat_o = '0;
    stat_o.clr_done   = clr_done_q;
    stat_o.is_alloc   = (req_q.kind == buddy_pkg::KindAlloc);
    stat_o.bad_size   = (req_q.request_size == '0) ||
                        (NeedW'(req_q.request_size) > (NeedW'(1) << POOL_LOG2));
    stat_o.too_big    = too_big;
    stat_o.bad_addr   = (req_q.free_address < 16'(hdr_q)) ||
                        ((NeedW'(req_q.free_address) - NeedW'(hdr_q)) >>
                         POOL_LOG2 != '0);
    stat_o.rd         = rd_q;
    stat_o.scan_last  = (dep_q == '0);
    stat_o.scan_top   = (idx_q == ((lvl_base << 1) - IdxW'(1)));
    stat_o.at_target  = (dep_q == tgt_q);
    stat_o.addr_match = (node_addr == a_q);
    stat_o.at_leaf    = (dep_q == DepW'(Levels));
    stat_o.at_root    = (idx_q == IdxW'(1));
  end

  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

// ----- rtl/buddy_ctrl.sv -----
// ----------------------------------------------------------------------------
// buddy_ctrl: buddy allocator controller
// Sequences clear sweep, search, split, descend and merge steps.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire buddy_pkg::stat_t stat_i,
  input  wire buddy_pkg::rsp_t  rsp_i,
  output buddy_pkg::cmd_e       cmd_o,
  output buddy_pkg::rsp_t       rsp_o
);
  typedef enum logic [3:0] {
    SClear, SIdle, SLoad, SScanWait, SScan, SSplit, SFreeWait, SWalk,
    SMergeWait, SMerge, SOut
  } state_e;

  state_e state_q;
  logic [1:0] err_q;
  logic err_set_q;
  logic [1:0] err_d;
  logic err_set_d;
  state_e state_d;
  buddy_pkg::rsp_t out_q;
  buddy_pkg::rsp_t out_d;

  always_comb begin
    cmd_o = buddy_pkg::CmdNone;
    state_d = state_q;
    err_d = err_q;
    err_set_d = err_set_q;
    case (state_q)
      SClear: begin
        cmd_o = buddy_pkg::CmdClrStep;
        if (stat_i.clr_done) begin
          cmd_o = buddy_pkg::CmdNone;
          state_d = SIdle;
        end
      end
      SIdle: if (in_valid_i) state_d = SLoad;
      SLoad: begin
        cmd_o = buddy_pkg::CmdLoad;
        err_set_d = 1'b1;
        if (stat_i.is_alloc) begin
          if (stat_i.bad_size) err_d = buddy_pkg::StBadSize;
          else if (stat_i.too_big) err_d = buddy_pkg::StNoRoom;
          else err_set_d = 1'b0;
          state_d = err_set_d ? SOut : SScanWait;
        end else begin
          if (stat_i.bad_addr) err_d = buddy_pkg::StBadFree;
          else err_set_d = 1'b0;
          state_d = err_set_d ? SOut : SFreeWait;
        end
      end
      SScanWait: state_d = SScan;
      SScan: begin
        if (stat_i.rd == buddy_pkg::NsFree) begin
          state_d = SSplit;
        end else if (stat_i.scan_top && stat_i.scan_last) begin
          err_set_d = 1'b1; err_d = buddy_pkg::StNoRoom; state_d = SOut;
        end else begin
          cmd_o = buddy_pkg::CmdScanNext; state_d = SScanWait;
        end
      end
      SSplit: begin
        if (stat_i.at_target) begin
          cmd_o = buddy_pkg::CmdMarkAlloc; state_d = SOut;
        end else begin
          cmd_o = buddy_pkg::CmdSplit;
        end
      end
      SFreeWait: state_d = SWalk;
      SWalk: begin
        if (stat_i.rd == buddy_pkg::NsAlloc) begin
          if (stat_i.addr_match) begin
            cmd_o = buddy_pkg::CmdMarkFree; state_d = SMergeWait;
          end else begin
            err_set_d = 1'b1; err_d = buddy_pkg::StBadFree; state_d = SOut;
          end
        end else if (stat_i.rd == buddy_pkg::NsSplit && !stat_i.at_leaf) begin
          cmd_o = buddy_pkg::CmdDescend; state_d = SFreeWait;
        end else begin
          err_set_d = 1'b1; err_d = buddy_pkg::StBadFree; state_d = SOut;
        end
      end
      SMergeWait: state_d = SMerge;
      SMerge: begin
        if (!stat_i.at_root && stat_i.rd == buddy_pkg::NsFree) begin
          cmd_o = buddy_pkg::CmdMerge; state_d = SMergeWait;
        end else begin
          cmd_o = buddy_pkg::CmdFinish; state_d = SOut;
        end
      end
      SOut: if (!out_valid_o || out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    out_d = rsp_i;
    if (err_set_q) begin
      out_d.status = err_q;
      out_d.block_size_log2 = '0;
      if (err_q != buddy_pkg::StBadFree) out_d.data_address = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      err_q <= '0;
      err_set_q <= 1'b0;
      out_valid_o <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      err_q <= err_d;
      err_set_q <= err_set_d;
      if (state_q == SOut && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
        out_q <= out_d;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign in_ready_o = (state_q == SIdle);
  assign rsp_o = out_q;
endmodule
`default_nettype wire

// ----- rtl/buddy_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_allocator: binary buddy allocator, top level
// Channel   | Handshake                 | Payload
// in        | in_valid_i / in_ready_o   | in_data_i  (buddy_pkg::req_t)
// out       | out_valid_o / out_ready_i | out_data_o (buddy_pkg::rsp_t)
// cfg       | cfg_we_i                  | cfg_wdata_i (header size)
// One item at a time. Allocate scans nodes and splits; free walks levels and
// merges. Every node read goes through the single node-status memory read
// port. After reset a clearing pass over all 2^(POOL_LOG2-MIN_LOG2+1) memory
// entries runs with in_ready_o low. A held result lets the next item run
// until its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_allocator #(
  parameter int unsigned POOL_LOG2 = buddy_pkg::PoolLog2Def,
  parameter int unsigned MIN_LOG2  = buddy_pkg::MinLog2Def
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [9:0]      cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire buddy_pkg::req_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output buddy_pkg::rsp_t      out_data_o
);
  buddy_pkg::cmd_e  cmd;
  buddy_pkg::stat_t stat;
  buddy_pkg::rsp_t  rsp;

  buddy_dp #(.POOL_LOG2(POOL_LOG2), .MIN_LOG2(MIN_LOG2)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .req_i(in_data_i), .cmd_i(cmd), .stat_o(stat), .rsp_o(rsp)
  );

  buddy_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .rsp_i(rsp), .cmd_o(cmd), .rsp_o(out_data_o)
  );
endmodule
`default_nettype wire

// ----- rtl/buddy_chk.sv -----
// ----------------------------------------------------------------------------
// buddy_chk: port checker for the buddy allocator
// Checks result codes and handshake behavior seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_chk (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire buddy_pkg::rsp_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");
  a_err_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != buddy_pkg::StDone |->
    out_data_o.block_size_log2 == '0)
    else $error("error result with size");
  a_alloc_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == buddy_pkg::StBadSize ||
    out_data_o.status == buddy_pkg::StNoRoom) |-> out_data_o.data_address == '0)
    else $error("allocate error with address");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken during work");
endmodule
bind buddy_allocator buddy_chk u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for buddy_allocator
// A table of directed beats (extremes, error codes, header settings), then
// random allocate/free traffic under several idle and stall phases. Every
// result is checked against an in-bench model of the buddy tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int unsigned Pool   = buddy_pkg::PoolLog2Def;
  localparam int unsigned MinBlk = buddy_pkg::MinLog2Def;
  localparam int unsigned Levels = Pool - MinBlk;
  localparam int unsigned Nodes  = 2 << Levels;
  localparam longint      CycleLimit = 64'd20_000_000;
  localparam int          HoldCycles = 3000;

  typedef enum logic [1:0] {OpAlloc, OpFree, OpCfg} row_op_e;

  typedef struct {
    row_op_e         op;
    logic [15:0]     arg;
    bit              known;
    buddy_pkg::rsp_t want;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we = 1'b0;
  logic [9:0]      cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  buddy_pkg::req_t in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  buddy_pkg::rsp_t out_data;

  always #2 clk_i = ~clk_i;

  buddy_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // tree model
  logic [1:0]      tree [Nodes];
  logic [9:0]      hdr;
  buddy_pkg::rsp_t pending_rsp [$];
  int unsigned     live_blk [$];
  int              errs = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  bit              hold_go = 1'b0;
  longint          cycles = 0;

  function automatic int unsigned blk_addr(int unsigned idx, int unsigned d);
    return (idx - (1 << d)) << (Pool - d);
  endfunction

  function automatic buddy_pkg::rsp_t tree_alloc(logic [15:0] req);
    int unsigned need, k, target, d, idx, i;
    bit found;
    buddy_pkg::rsp_t r;
    r = '0;
    idx = 0;
    found = 1'b0;
    if (req == 0 || 64'(req) > (64'd1 << Pool)) begin
      r.status = buddy_pkg::StBadSize;
      return r;
    end
    need = req + hdr;
    k = MinBlk;
    while (k <= Pool && (1 << k) < need) k++;
    if (k > Pool) begin
      r.status = buddy_pkg::StNoRoom;
      return r;
    end
    target = Pool - k;
    // deepest fitting level first, lowest address within a level
    d = target + 1;
    while (d > 0 && !found) begin
      d--;
      for (i = 1 << d; i < (2 << d); i++) begin
        if (tree[i] == buddy_pkg::NsFree) begin
          idx = i;
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) begin
      r.status = buddy_pkg::StNoRoom;
      return r;
    end
    while (d < target) begin
      tree[idx] = buddy_pkg::NsSplit;
      tree[2*idx] = buddy_pkg::NsFree;
      tree[2*idx+1] = buddy_pkg::NsFree;
      idx = 2 * idx;
      d++;
    end
    tree[idx] = buddy_pkg::NsAlloc;
    r.status = buddy_pkg::StDone;
    r.data_address = 16'(blk_addr(idx, d) + hdr);
    r.block_size_log2 = 5'(k);
    return r;
  endfunction

  function automatic buddy_pkg::rsp_t tree_free(logic [15:0] faddr);
    int unsigned a, idx, d;
    buddy_pkg::rsp_t r;
    r = '0;
    r.status = buddy_pkg::StBadFree;
    r.data_address = faddr;
    idx = 1;
    d = 0;
    if (faddr < hdr) return r;
    a = faddr - hdr;
    if (64'(a) >= (64'd1 << Pool)) return r;
    forever begin
      if (tree[idx] == buddy_pkg::NsAlloc) begin
        if (a != blk_addr(idx, d)) return r;
        break;
      end
      if (tree[idx] == buddy_pkg::NsSplit && d < Levels) begin
        idx = 2 * idx + ((a >> (Pool - d - 1)) & 1);
        d++;
      end else begin
        return r;
      end
    end
    tree[idx] = buddy_pkg::NsFree;
    while (idx > 1 && tree[idx ^ 1] == buddy_pkg::NsFree) begin
      tree[idx] = buddy_pkg::NsUnused;
      tree[idx ^ 1] = buddy_pkg::NsUnused;
      idx >>= 1;
      tree[idx] = buddy_pkg::NsFree;
      d--;
    end
    r.status = buddy_pkg::StDone;
    r.block_size_log2 = 5'(Pool - d);
    return r;
  endfunction

  // present one beat, wait for acceptance, then record the expected result
  task automatic send_beat(input buddy_pkg::req_t r, input bit known,
                           input buddy_pkg::rsp_t want);
    buddy_pkg::rsp_t p;
    int i;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk_i); while (!in_ready);
    if (r.kind == buddy_pkg::KindAlloc) p = tree_alloc(r.request_size);
    else p = tree_free(r.free_address);
    if (known && p != want) begin
      $error("table row disagrees with model: %h vs %h", want, p);
      errs++;
    end
    pending_rsp.push_back(p);
    if (p.status == buddy_pkg::StDone) begin
      if (r.kind == buddy_pkg::KindAlloc) begin
        live_blk.push_back(32'(16'(p.data_address - hdr)));
      end else begin
        for (i = 0; i < live_blk.size(); i++) begin
          if (live_blk[i] == 32'(16'(r.free_address - hdr))) begin
            live_blk.delete(i);
            break;
          end
        end
      end
    end
  endtask

  task automatic write_header(input logic [9:0] v);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    hdr = v;
  endtask

  task automatic run_row(input row_t row);
    buddy_pkg::req_t r;
    r.kind = (row.op == OpFree);
    r.request_size = (row.op == OpAlloc) ? row.arg : 16'($urandom);
    r.free_address = (row.op == OpFree) ? row.arg : 16'($urandom);
    if (row.op == OpCfg) write_header(row.arg[9:0]);
    else send_beat(r, row.known, row.want);
  endtask

  function automatic logic [15:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 3) return 16'd0;
    if (sel < 8) return 16'($urandom);
    if (sel < 12) return 16'($urandom_range(65535, 60000));
    if (sel < 30) return 16'($urandom_range(16000, 1));
    return 16'($urandom_range(2000, 1));
  endfunction

  task automatic random_beat();
    buddy_pkg::req_t r;
    int unsigned sel;
    r.request_size = 16'($urandom);
    r.free_address = 16'($urandom);
    sel = $urandom_range(99);
    if (live_blk.size() > 40) sel = sel / 2 + 50;
    if (sel < 50) begin
      r.kind = buddy_pkg::KindAlloc;
      r.request_size = pick_size();
    end else begin
      r.kind = ~buddy_pkg::KindAlloc;
      if (sel < 90 && live_blk.size() != 0)
        r.free_address = 16'(live_blk[$urandom_range(live_blk.size() - 1)] + hdr);
      else if (sel < 95 && live_blk.size() != 0)
        r.free_address = 16'(live_blk[$urandom_range(live_blk.size() - 1)] + hdr
                             + $urandom_range(64, 1));
    end
    send_beat(r, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk_i) begin
    buddy_pkg::rsp_t w;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        errs++;
      end else begin
        w = pending_rsp.pop_front();
        if (out_data.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_data.status);
          errs++;
        end
        if (out_data.data_address !== w.data_address) begin
          $error("data_address: expected %0d, got %0d", w.data_address,
                 out_data.data_address);
          errs++;
        end
        if (out_data.block_size_log2 !== w.block_size_log2) begin
          $error("block_size_log2: expected %0d, got %0d", w.block_size_log2,
                 out_data.block_size_log2);
          errs++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    logic [9:0] hdr_list [6];
    int n, p;
    hdr_list = '{10'd0, 10'd1023, 10'd64, 10'd300, 10'd7, 10'd128};
    rows = '{
      '{OpAlloc, 16'd0,     1'b1, '{buddy_pkg::StBadSize, 16'd0, 5'd0}},
      '{OpAlloc, 16'd65535, 1'b1, '{buddy_pkg::StNoRoom, 16'd0, 5'd0}},
      '{OpFree,  16'd0,     1'b1, '{buddy_pkg::StBadFree, 16'd0, 5'd0}},
      '{OpFree,  16'd65535, 1'b1, '{buddy_pkg::StBadFree, 16'd65535, 5'd0}},
      '{OpFree,  16'd128,   1'b1, '{buddy_pkg::StBadFree, 16'd128, 5'd0}},
      '{OpAlloc, 16'd65408, 1'b1, '{buddy_pkg::StDone, 16'd128, 5'd16}},
      '{OpAlloc, 16'd1,     1'b1, '{buddy_pkg::StNoRoom, 16'd0, 5'd0}},
      '{OpFree,  16'd128,   1'b1, '{buddy_pkg::StDone, 16'd128, 5'd16}},
      '{OpAlloc, 16'd1,     1'b1, '{buddy_pkg::StDone, 16'd128, 5'd8}},
      '{OpAlloc, 16'd1,     1'b0, '0},
      '{OpAlloc, 16'd300,   1'b0, '0},
      '{OpFree,  16'd384,   1'b0, '0},
      '{OpFree,  16'd384,   1'b0, '0},
      '{OpAlloc, 16'd5000,  1'b0, '0},
      '{OpFree,  16'd128,   1'b0, '0},
      '{OpCfg,   16'd0,     1'b0, '0},
      '{OpAlloc, 16'd65535, 1'b0, '0},
      '{OpAlloc, 16'd64,    1'b0, '0},
      '{OpCfg,   16'd1023,  1'b0, '0},
      '{OpAlloc, 16'd65535, 1'b0, '0},
      '{OpAlloc, 16'd32768, 1'b0, '0},
      '{OpFree,  16'd1023,  1'b0, '0},
      '{OpFree,  16'd65535, 1'b0, '0},
      '{OpCfg,   16'd128,   1'b0, '0}
    };
    foreach (tree[i]) tree[i] = buddy_pkg::NsUnused;
    tree[1] = buddy_pkg::NsFree;
    hdr = buddy_pkg::HeaderReset;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) run_row(rows[i]);

    for (p = 0; p < 6; p++) begin
      write_header(hdr_list[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      if (p == 4) hold_go = 1'b1;
      for (n = 0; n < 272; n++) random_beat();
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errs == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
